// File: hw/rtl/bcd_arithmetic_unit_assert.svh
// Assertion helpers for the RTL files, included by bcd_arithmetic_unit.sv.
`ifndef BCD_ARITHMETIC_UNIT_ASSERT_SVH
`define BCD_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bau_pkg.sv
package bau_pkg;

	localparam int ACTION_W = 3;
	localparam int WORD_W   = 16;
	localparam int BYTE_W   = 8;

	// Instruction codes
	localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_NEG  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_PACK = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_UNPK = 3'd4;

	// Decimal wrap for two-digit arithmetic
	localparam logic [9:0] DEC_WRAP = 10'd100;

	// Reciprocal of ten for byte-wide values: (v * 205) >> 11
	localparam logic [15:0] RECIP_TEN = 16'd205;
	localparam int          RECIP_SH  = 11;

	typedef struct packed {
		logic x;
		logic c;
		logic z;
	} bau_flags_t;

	// High digit times ten plus low digit, invalid digits used as they are
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'b0, b[7:4]};
		lo = {4'b0, b[3:0]};
		return (hi << 3) + (hi << 1) + lo;
	endfunction

	// Byte to packed BCD, tens digit cut to four bits
	function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
		logic [15:0] prod;
		logic [7:0]  q;
		logic [7:0]  r;
		prod = {8'b0, v} * RECIP_TEN;
		q    = {3'b0, prod[RECIP_SH+4:RECIP_SH]};
		r    = v - (q << 3) - (q << 1);
		return {q[3:0], r[3:0]};
	endfunction

endpackage

// File: hw/rtl/bau_alu.sv
module bau_alu
	import bau_pkg::*;
(
	input  logic [ACTION_W-1:0] action,
	input  logic [WORD_W-1:0]   first_operand,
	input  logic [BYTE_W-1:0]   second_operand,
	input  logic signed [WORD_W-1:0] adjustment,
	input  bau_flags_t          flags_in,
	output logic [WORD_W-1:0]   result,
	output bau_flags_t          flags_out
);

	logic [7:0]  a_bin;
	logic [7:0]  b_bin;
	logic [9:0]  add_sum;
	logic        add_cy;
	logic [9:0]  add_d;
	logic [9:0]  sub_raw;
	logic        sub_bw;
	logic [9:0]  sub_d;
	logic [9:0]  neg_raw;
	logic        neg_bw;
	logic [7:0]  neg_d;
	logic [7:0]  bcd_src;
	logic [7:0]  bcd_byte;
	logic [15:0] pack_sum;
	logic [15:0] unpk_word;

	// Operand bytes to binary
	assign a_bin = bcd_to_bin(first_operand[7:0]);
	assign b_bin = bcd_to_bin(second_operand);

	// Add with extend, correct by one hundred on decimal carry
	assign add_sum = {2'b0, a_bin} + {2'b0, b_bin} + {9'b0, flags_in.x};
	assign add_cy  = add_sum >= DEC_WRAP;
	assign add_d   = add_cy ? add_sum - DEC_WRAP : add_sum;

	// Subtract with extend, correct by one hundred on borrow
	assign sub_raw = {2'b0, a_bin} - {2'b0, b_bin} - {9'b0, flags_in.x};
	assign sub_bw  = sub_raw[9];
	assign sub_d   = sub_bw ? sub_raw + DEC_WRAP : sub_raw;

	// Negate with extend; exactly one hundred means no borrow and a zero byte
	assign neg_raw = DEC_WRAP - {2'b0, a_bin} - {9'b0, flags_in.x};
	assign neg_bw  = neg_raw[7:0] != DEC_WRAP[7:0];
	assign neg_d   = neg_bw ? neg_raw[7:0] : 8'd0;

	// Pack and unpack words
	assign pack_sum  = first_operand + $unsigned(adjustment);
	assign unpk_word = {4'b0, first_operand[7:4], 4'b0, first_operand[3:0]}
		+ $unsigned(adjustment);

	// One shared conversion back to BCD
	always_comb begin
		case (action)
			ACT_ADD: bcd_src = add_d[7:0];
			ACT_SUB: bcd_src = sub_d[7:0];
			default: bcd_src = neg_d;
		endcase
	end

	assign bcd_byte = bin_to_bcd(bcd_src);

	// Select result and flags
	always_comb begin
		result    = '0;
		flags_out = flags_in;
		case (action)
			ACT_ADD: begin
				result      = {8'b0, bcd_byte};
				flags_out.x = add_cy;
				flags_out.c = add_cy;
				if (add_d != 10'd0) flags_out.z = 1'b0;
			end
			ACT_SUB: begin
				result      = {8'b0, bcd_byte};
				flags_out.x = sub_bw;
				flags_out.c = sub_bw;
				if (sub_d != 10'd0) flags_out.z = 1'b0;
			end
			ACT_NEG: begin
				result      = {8'b0, bcd_byte};
				flags_out.x = neg_bw;
				flags_out.c = neg_bw;
				if (neg_d != 8'd0) flags_out.z = 1'b0;
			end
			ACT_PACK: begin
				result = {8'b0, pack_sum[11:8], pack_sum[3:0]};
			end
			ACT_UNPK: begin
				result = unpk_word;
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/bcd_arithmetic_unit.sv
// Packed-BCD arithmetic unit: add, subtract and negate with extend, pack, unpack.
// Command channel: an item is taken at a rising edge with start high and busy
// low. busy is held low, so a new item may be issued in every cycle.
// Each item carries the action code, operands, the signed adjustment word and
// the incoming X, C and Z flags; the unit itself holds no flag state.
// Result channel: done is high for exactly one cycle with result, extend_out,
// carry_out and zero_out valid in that cycle. The receiver has no way to hold
// results off, and none is needed: results leave in issue order.
// Pipeline: the item is registered in the stage 1 registers, the result is
// computed in one pass through the ALU and registered in the stage 2
// registers, which drive done and the result outputs.
// Throughput: one item per cycle, set by the single ALU pass between the
// input and result registers.
// Reset (arst_n low) clears both stage valid bits, so no done is issued
// for items taken before reset.
`include "bcd_arithmetic_unit_assert.svh"

module bcd_arithmetic_unit
	import bau_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ACTION_W-1:0]      action,
	input  logic [WORD_W-1:0]        first_operand,
	input  logic [BYTE_W-1:0]        second_operand,
	input  logic signed [WORD_W-1:0] adjustment,
	input  logic                     extend_in,
	input  logic                     carry_in,
	input  logic                     zero_in,
	output logic                     done,
	output logic [WORD_W-1:0]        result,
	output logic                     extend_out,
	output logic                     carry_out,
	output logic                     zero_out
);

	logic                     accept;
	logic                     valid_s1;
	logic [ACTION_W-1:0]      action_s1;
	logic [WORD_W-1:0]        first_s1;
	logic [BYTE_W-1:0]        second_s1;
	logic signed [WORD_W-1:0] adjust_s1;
	bau_flags_t               flags_s1;
	logic [WORD_W-1:0]        alu_result;
	bau_flags_t               alu_flags;
	logic                     done_s2;
	logic [ACTION_W-1:0]      action_s2;
	logic [WORD_W-1:0]        result_s2;
	bau_flags_t               flags_s2;
	logic                     act_is_bcd;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			first_s1   <= first_operand;
			second_s1  <= second_operand;
			adjust_s1  <= adjustment;
			flags_s1.x <= extend_in;
			flags_s1.c <= carry_in;
			flags_s1.z <= zero_in;
		end
	end

	bau_alu u_alu (
		.action         (action_s1),
		.first_operand  (first_s1),
		.second_operand (second_s1),
		.adjustment     (adjust_s1),
		.flags_in       (flags_s1),
		.result         (alu_result),
		.flags_out      (alu_flags)
	);

	// Stage 2 strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			action_s2 <= action_s1;
			result_s2 <= alu_result;
			flags_s2  <= alu_flags;
		end
	end

	assign done       = done_s2;
	assign result     = result_s2;
	assign extend_out = flags_s2.x;
	assign carry_out  = flags_s2.c;
	assign zero_out   = flags_s2.z;

	// Flag the decimal instructions, whose carry follows extend
	assign act_is_bcd = action_s2 inside {ACT_ADD, ACT_SUB, ACT_NEG};

	`BAU_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, accept, valid_s1, "accepted item lost")
	`BAU_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1, done_s2, "stage 1 item not issued")
	`BAU_ASSERT_NOW(a_done_has_src, clk, arst_n, done_s2, $past(valid_s1), "done without item")
	`BAU_ASSERT_NOW(a_bcd_c_eq_x, clk, arst_n, done_s2 && act_is_bcd,
		carry_out == extend_out, "carry differs from extend")
	`BAU_ASSERT_NOW(a_byte_result, clk, arst_n, done_s2 && action_s2 != ACT_UNPK,
		result[15:8] == 8'd0, "upper byte set")

endmodule
